[rtl/fpiv_pkg.sv]
// Shared constants, types and helpers of the frustum point-in-view test.
package fpiv_pkg;

  localparam int PLANES_PER_SECTOR = 6;
  localparam int SECTORS           = 4;
  localparam int COORD_WIDTH       = 32;

  localparam int TABLE_DEPTH = SECTORS * PLANES_PER_SECTOR;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PIS_W       = $clog2(PLANES_PER_SECTOR);
  localparam int COORD_SHIFT = 32 - COORD_WIDTH;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PANORAMIC = 3'd6;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] off;
  } plane_t;

  // Tag that travels with one plane through the dot-product pipeline.
  typedef struct packed {
    logic valid;
    logic sector_end;
    logic last;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic sector_end;
    logic last;
  } res_t;

  // Keeps the low COORD_WIDTH bits of a coordinate, sign-extended to 32 bits.
  function automatic logic signed [31:0] sext_coord(input logic [31:0] v);
    logic [31:0] shifted;
    shifted = v << COORD_SHIFT;
    return $signed(shifted) >>> COORD_SHIFT;
  endfunction

endpackage

[rtl/fpiv_plane_mem.sv]
// Plane table: one write port for load words, one registered read port.
module fpiv_plane_mem (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [fpiv_pkg::IDX_W-1:0] wr_addr_i,
  input  fpiv_pkg::plane_t      wr_data_i,
  input  logic                  rd_en_i,
  input  logic [fpiv_pkg::IDX_W-1:0] rd_addr_i,
  output fpiv_pkg::plane_t      rd_data_o
);
  import fpiv_pkg::*;

  plane_t mem_q [TABLE_DEPTH];
  plane_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/fpiv_dot_unit.sv]
// Shared plane unit: one exact normal.point >= offset test per cycle, pipelined.
module fpiv_dot_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpiv_pkg::tag_t     tag_i,
  input  fpiv_pkg::plane_t   plane_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output fpiv_pkg::res_t     res_o
);
  import fpiv_pkg::*;

  tag_t tag_a_q, tag_b_q, tag_c_q;
  res_t res_q;

  logic signed [63:0] prod_x_q, prod_y_q, prod_z_q, off_q;
  logic signed [64:0] s01_q, s23_q;
  logic signed [65:0] total;

  // The offset in Q16.16 is moved to the Q18.46 scale of the products.
  always_ff @(posedge clk_i) begin
    prod_x_q <= $signed(plane_i.nx) * point_x_i;
    prod_y_q <= $signed(plane_i.ny) * point_y_i;
    prod_z_q <= $signed(plane_i.nz) * point_z_i;
    off_q    <= $signed({{2{plane_i.off[31]}}, plane_i.off, 30'd0});
    s01_q    <= $signed({prod_x_q[63], prod_x_q}) + $signed({prod_y_q[63], prod_y_q});
    s23_q    <= $signed({prod_z_q[63], prod_z_q}) - $signed({off_q[63], off_q});
  end

  assign total = $signed({s01_q[64], s01_q}) + $signed({s23_q[64], s23_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
      res_q   <= '0;
    end else begin
      tag_a_q          <= tag_i;
      tag_b_q          <= tag_a_q;
      tag_c_q          <= tag_b_q;
      res_q.valid      <= tag_c_q.valid;
      res_q.sector_end <= tag_c_q.sector_end;
      res_q.last       <= tag_c_q.last;
      res_q.ok         <= ~total[65];
    end
  end

  assign res_o = res_q;

endmodule

[rtl/fpiv_ctrl.sv]
// Sequencer: walks the plane table for a query and holds the result word.
module fpiv_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic                       inside_box_i,
  input  logic                       panoramic_i,
  output fpiv_pkg::tag_t             issue_o,
  output logic [fpiv_pkg::IDX_W-1:0] rd_addr_o,
  input  fpiv_pkg::res_t             res_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       in_view_o,
  output logic                       inside_box_o
);
  import fpiv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FINISH} state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   last_idx_q;
  logic [PIS_W-1:0]   pis_q;
  logic               sector_ok_q;
  logic               view_q;
  logic               inside_q;
  logic               out_valid_q;
  logic               in_view_q;
  logic               inside_box_q;
  logic               accept_query;

  assign in_ready_o   = (state_q == S_IDLE);
  assign accept_query = in_valid_i && in_ready_o && (mode_i == MODE_QUERY);

  assign issue_o.valid      = (state_q == S_RUN);
  assign issue_o.sector_end = (pis_q == PIS_W'(PLANES_PER_SECTOR - 1));
  assign issue_o.last       = (cnt_q == last_idx_q);
  assign rd_addr_o          = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      last_idx_q   <= '0;
      pis_q        <= '0;
      sector_ok_q  <= 1'b1;
      view_q       <= 1'b0;
      inside_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      in_view_q    <= 1'b0;
      inside_box_q <= 1'b0;
    end else begin
      // In S_FINISH the output register is handled by the state itself.
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      // A sector passes only if all of its planes pass; any passing sector wins.
      if (res_i.valid) begin
        if (res_i.sector_end) begin
          view_q      <= view_q | (sector_ok_q & res_i.ok);
          sector_ok_q <= 1'b1;
        end else begin
          sector_ok_q <= sector_ok_q & res_i.ok;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept_query) begin
            inside_q    <= inside_box_i;
            view_q      <= 1'b0;
            sector_ok_q <= 1'b1;
            cnt_q       <= '0;
            pis_q       <= '0;
            last_idx_q  <= panoramic_i ? IDX_W'(TABLE_DEPTH - 1)
                                       : IDX_W'(PLANES_PER_SECTOR - 1);
            state_q     <= inside_box_i ? S_RUN : S_FINISH;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          pis_q <= issue_o.sector_end ? '0 : pis_q + 1'b1;
          if (issue_o.last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res_i.valid && res_i.last) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            in_view_q    <= view_q & inside_q;
            inside_box_q <= inside_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_view_o    = in_view_q;
  assign inside_box_o = inside_box_q;

endmodule

[rtl/frustum_point_in_view_test.sv]
// Top level of the frustum point-in-view test: registers, box check and datapath.
// A load word (mode 0) writes one plane into the 24-entry table and gives no
// result; an index beyond the table is dropped. A query word (mode 1) is checked
// against the inclusive box in its accept cycle; for a point outside the box the
// sequencer goes straight to its finish state, which loads the output register. A
// point inside the box is tested against one plane per cycle by a single pipelined
// multiply-add unit fed from the plane table, 6 planes in limited mode and all 24
// in panoramic mode; each plane passes table read, multiply, add and result. The
// input is not ready while a query is in progress; a finished result waits in the
// output register while the next word is accepted. The plane test is exact, with
// no rounding.
module frustum_point_in_view_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpiv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [4:0]                        plane_index_i,
  input  logic signed [31:0]                normal_x_i,
  input  logic signed [31:0]                normal_y_i,
  input  logic signed [31:0]                normal_z_i,
  input  logic signed [31:0]                plane_offset_i,
  input  logic signed [31:0]                point_x_i,
  input  logic signed [31:0]                point_y_i,
  input  logic signed [31:0]                point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              in_view_o,
  output logic                              inside_box_o
);
  import fpiv_pkg::*;

  logic [31:0] box_min_x_q, box_min_y_q, box_min_z_q;
  logic [31:0] box_max_x_q, box_max_y_q, box_max_z_q;
  logic        panoramic_q;

  logic signed [31:0] px, py, pz;
  logic signed [31:0] point_x_q, point_y_q, point_z_q;
  logic               inside_box;
  logic               accept;
  logic               mem_we;
  plane_t             wr_plane;
  plane_t             rd_plane;
  tag_t               issue;
  res_t               res;
  logic [IDX_W-1:0]   rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_x_q <= 32'h8000_0000;
      box_min_y_q <= 32'h8000_0000;
      box_min_z_q <= 32'h8000_0000;
      box_max_x_q <= 32'h7FFF_FFFF;
      box_max_y_q <= 32'h7FFF_FFFF;
      box_max_z_q <= 32'h7FFF_FFFF;
      panoramic_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_MIN_X: box_min_x_q <= cfg_data_i;
        REG_BOX_MIN_Y: box_min_y_q <= cfg_data_i;
        REG_BOX_MIN_Z: box_min_z_q <= cfg_data_i;
        REG_BOX_MAX_X: box_max_x_q <= cfg_data_i;
        REG_BOX_MAX_Y: box_max_y_q <= cfg_data_i;
        REG_BOX_MAX_Z: box_max_z_q <= cfg_data_i;
        REG_PANORAMIC: panoramic_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign px = sext_coord(point_x_i);
  assign py = sext_coord(point_y_i);
  assign pz = sext_coord(point_z_i);

  assign inside_box = (px >= sext_coord(box_min_x_q)) && (px <= sext_coord(box_max_x_q)) &&
                      (py >= sext_coord(box_min_y_q)) && (py <= sext_coord(box_max_y_q)) &&
                      (pz >= sext_coord(box_min_z_q)) && (pz <= sext_coord(box_max_z_q));

  assign accept = in_valid_i && in_ready_o;

  // The point is held for the whole query; the datapath reads it from here.
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == MODE_QUERY)) begin
      point_x_q <= px;
      point_y_q <= py;
      point_z_q <= pz;
    end
  end

  assign mem_we = accept && (mode_i == MODE_LOAD) && (int'(plane_index_i) < TABLE_DEPTH);

  assign wr_plane.nx  = normal_x_i;
  assign wr_plane.ny  = normal_y_i;
  assign wr_plane.nz  = normal_z_i;
  assign wr_plane.off = plane_offset_i;

  fpiv_plane_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (IDX_W'(plane_index_i)),
    .wr_data_i (wr_plane),
    .rd_en_i   (issue.valid),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_plane)
  );

  fpiv_dot_unit u_dot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (issue),
    .plane_i   (rd_plane),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .point_z_i (point_z_q),
    .res_o     (res)
  );

  fpiv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .inside_box_i (inside_box),
    .panoramic_i  (panoramic_q),
    .issue_o      (issue),
    .rd_addr_o    (rd_addr),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_view_o    (in_view_o),
    .inside_box_o (inside_box_o)
  );

  // Only an accepted query word takes the input side out of ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && (mode_i == MODE_QUERY)))
    else $error("input went busy without a query word");

  // A load word completes in its accept cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_LOAD)) |=> in_ready_o)
    else $error("load word left the input busy");

  // Plane results only arrive while a query is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !in_ready_o)
    else $error("plane result while idle");

  // A point in view is always inside the box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!in_view_o || inside_box_o))
    else $error("in_view set for a point outside the box");

endmodule
